[rtl/core/psp_pkg.sv]
// ----------------------------------------------------------------------------
// psp_pkg
// Types, character codes and helpers shared by the printf spec parser.
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

  // Input transaction: one format character plus the star argument.
  typedef struct packed {
    logic        [7:0]  ch;
    logic signed [31:0] arg_value;
  } psp_in_t;

  // Parsed conversion record.
  typedef struct packed {
    logic               valid_res;
    logic        [7:0]  conv_char;
    logic               flag_hash;
    logic               flag_minus;
    logic               flag_plus;
    logic               flag_space;
    logic               flag_zero;
    logic        [30:0] field_width;
    logic               has_dot;
    logic signed [31:0] precision;
    logic        [3:0]  length_mod;
  } psp_out_t;

  typedef enum logic [3:0] {
    PH_FLAGS  = 4'd0,
    PH_WDIG   = 4'd1,
    PH_WSTAR  = 4'd2,
    PH_DOT    = 4'd3,
    PH_PSTART = 4'd4,
    PH_PDIG   = 4'd5,
    PH_PSTAR  = 4'd6,
    PH_LEN    = 4'd7,
    PH_LENH   = 4'd8,
    PH_LENL   = 4'd9,
    PH_CONV   = 4'd10
  } psp_phase_e;

  // Flag bit positions
  localparam int unsigned FB_HASH  = 0;
  localparam int unsigned FB_MINUS = 1;
  localparam int unsigned FB_PLUS  = 2;
  localparam int unsigned FB_SPACE = 3;
  localparam int unsigned FB_ZERO  = 4;
  localparam int unsigned NumFlags = 5;

  // Length modifier codes
  localparam logic [3:0] LEN_NONE = 4'd0;
  localparam logic [3:0] LEN_HH   = 4'd1;
  localparam logic [3:0] LEN_H    = 4'd2;
  localparam logic [3:0] LEN_L    = 4'd3;
  localparam logic [3:0] LEN_LL   = 4'd4;
  localparam logic [3:0] LEN_J    = 4'd5;
  localparam logic [3:0] LEN_Z    = 4'd6;
  localparam logic [3:0] LEN_T    = 4'd7;
  localparam logic [3:0] LEN_BIGL = 4'd8;

  localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_ONE    = "1";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_LOW_H  = "h";
  localparam logic [7:0] CH_LOW_L  = "l";
  localparam logic [7:0] CH_LOW_J  = "j";
  localparam logic [7:0] CH_LOW_Z  = "z";
  localparam logic [7:0] CH_LOW_T  = "t";
  localparam logic [7:0] CH_UP_L   = "L";
  localparam logic [7:0] CH_LOW_C  = "c";
  localparam logic [7:0] CH_LOW_S  = "s";

  // Supported conversion characters: %cspdiuxXbonfFeEaAgG
  function automatic logic is_conv(input logic [7:0] c);
    logic r;
    unique case (c)
      "%", "c", "s", "p", "d", "i", "u", "x", "X", "b",
      "o", "n", "f", "F", "e", "E", "a", "A", "g", "G": r = 1'b1;
      default:                                          r = 1'b0;
    endcase
    return r;
  endfunction

  // acc * 10 + digit, saturating at SAT_MAX
  function automatic logic [30:0] sat_push(input logic [30:0] acc, input logic [3:0] dig);
    logic [34:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, dig};
    return (sum > {4'd0, SAT_MAX}) ? SAT_MAX : sum[30:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/printf_spec_parser_core.sv]
// ----------------------------------------------------------------------------
// printf_spec_parser_core
// Parses one printf conversion specification, one character per transaction.
// ----------------------------------------------------------------------------
// Feed the characters that follow a '%' one per transaction; the conversion
// character (or NUL, or any unsupported character reached at the conversion
// point) produces one record and returns the parser to its start state.
// Throughput is one character per clock while the output is not stalled:
// each transaction is held in an input register while a single pass of logic
// (one saturating multiply-by-ten add and the phase walk) updates the parse
// state and, on the conversion character, loads the result register. The
// conversion character passes the input register, then the result register.
// Star arguments are sampled from arg_value on the character ending the
// star's digits.
`default_nettype none

module printf_spec_parser_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire psp_pkg::psp_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output psp_pkg::psp_out_t      out_data_o
);
  import psp_pkg::*;

  // input register
  logic    in_valid_q;
  psp_in_t in_data_q;

  // parse state
  psp_phase_e           phase_q, phase_d;
  logic [NumFlags-1:0]  flags_q, flags_d;
  logic [30:0]          width_q, width_d;
  logic signed [31:0]   prec_q, prec_d;
  logic                 dot_q, dot_d;
  logic                 spn_q, spn_d;
  logic [3:0]           len_q, len_d;

  // result register
  logic     out_valid_q;
  psp_out_t out_data_q;

  logic        advance, process, emit, done;
  logic [7:0]  ch;
  logic [31:0] arg;
  logic        is_dig;
  logic [3:0]  dval;
  logic [30:0] pushed;
  logic [31:0] neg_arg;
  logic        valid_res;

  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  assign ch      = in_data_q.ch;
  assign arg     = in_data_q.arg_value;
  assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval    = 4'(ch - CH_ZERO);
  assign neg_arg = 32'd0 - arg;
  // only one digit run can be pushed per character
  assign pushed  = sat_push((phase_q == PH_WDIG) ? width_q : prec_q[30:0], dval);

  always_comb begin
    phase_d = phase_q;
    flags_d = flags_q;
    width_d = width_q;
    prec_d  = prec_q;
    dot_d   = dot_q;
    spn_d   = spn_q;
    len_d   = len_q;
    done    = 1'b0;
    emit    = 1'b0;

    if (phase_d == PH_FLAGS) begin
      done = 1'b1;
      if (ch == CH_HASH) begin
        flags_d[FB_HASH] = 1'b1;
      end else if (ch == CH_MINUS) begin
        flags_d[FB_MINUS] = 1'b1;
      end else if (ch == CH_PLUS) begin
        flags_d[FB_PLUS] = 1'b1;
      end else if (ch == CH_SPACE) begin
        flags_d[FB_SPACE] = 1'b1;
      end else if (ch == CH_ZERO) begin
        flags_d[FB_ZERO] = 1'b1;
      end else if ((ch >= CH_ONE) && (ch <= CH_NINE)) begin
        width_d = {27'd0, dval};
        phase_d = PH_WDIG;
      end else if (ch == CH_STAR) begin
        spn_d   = 1'b0;
        phase_d = PH_WSTAR;
      end else begin
        done    = 1'b0;
        phase_d = PH_DOT;
      end
    end

    if (!done && phase_d == PH_WDIG) begin
      if (is_dig) begin
        width_d = pushed;
        done    = 1'b1;
      end else begin
        phase_d = PH_DOT;
      end
    end

    if (!done && phase_d == PH_WSTAR) begin
      if (is_dig) begin
        if (ch != CH_ZERO) spn_d = 1'b1;
        done = 1'b1;
      end else begin
        if (arg[31]) begin
          flags_d[FB_MINUS] = 1'b1;
          // most negative value has no positive twin: saturate
          width_d = neg_arg[31] ? SAT_MAX : neg_arg[30:0];
        end else begin
          width_d = arg[30:0];
        end
        phase_d = PH_DOT;
        if (spn_d && ch == CH_DOLLAR) done = 1'b1;
      end
    end

    if (!done && phase_d == PH_DOT) begin
      if (ch == CH_DOT) begin
        dot_d   = 1'b1;
        phase_d = PH_PSTART;
        done    = 1'b1;
      end else begin
        phase_d = PH_LEN;
      end
    end

    if (!done && phase_d == PH_PSTART) begin
      done = 1'b1;
      if (ch == CH_STAR) begin
        spn_d   = 1'b0;
        phase_d = PH_PSTAR;
      end else if (is_dig) begin
        prec_d  = {28'd0, dval};
        phase_d = PH_PDIG;
      end else begin
        prec_d  = '0;
        phase_d = PH_LEN;
        done    = 1'b0;
      end
    end

    if (!done && phase_d == PH_PDIG) begin
      if (is_dig) begin
        prec_d = {1'b0, pushed};
        done   = 1'b1;
      end else begin
        phase_d = PH_LEN;
      end
    end

    if (!done && phase_d == PH_PSTAR) begin
      if (is_dig) begin
        if (ch != CH_ZERO) spn_d = 1'b1;
        done = 1'b1;
      end else begin
        prec_d  = arg;
        phase_d = PH_LEN;
        if (spn_d && ch == CH_DOLLAR) done = 1'b1;
      end
    end

    if (!done) begin
      if (phase_d == PH_LEN) begin
        done = 1'b1;
        if (ch == CH_LOW_H) begin
          phase_d = PH_LENH;
        end else if (ch == CH_LOW_L) begin
          phase_d = PH_LENL;
        end else if (ch == CH_LOW_J) begin
          len_d   = LEN_J;
          phase_d = PH_CONV;
        end else if (ch == CH_LOW_Z) begin
          len_d   = LEN_Z;
          phase_d = PH_CONV;
        end else if (ch == CH_LOW_T) begin
          len_d   = LEN_T;
          phase_d = PH_CONV;
        end else if (ch == CH_UP_L) begin
          len_d   = LEN_BIGL;
          phase_d = PH_CONV;
        end else begin
          phase_d = PH_CONV;
          done    = 1'b0;
        end
      end else if (phase_d == PH_LENH) begin
        if (ch == CH_LOW_H) begin
          len_d = LEN_HH;
          done  = 1'b1;
        end else begin
          len_d = LEN_H;
        end
        phase_d = PH_CONV;
      end else if (phase_d == PH_LENL) begin
        if (ch == CH_LOW_L) begin
          len_d = LEN_LL;
          done  = 1'b1;
        end else begin
          len_d = LEN_L;
        end
        phase_d = PH_CONV;
      end
    end

    emit = !done;
  end

  // NUL is not in the conversion set, so it yields an invalid record
  assign valid_res = is_conv(ch) &&
                     !(((ch == CH_LOW_C) || (ch == CH_LOW_S)) && (len_d == LEN_L));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAGS;
      flags_q <= '0;
      width_q <= '0;
      prec_q  <= '0;
      dot_q   <= 1'b0;
      spn_q   <= 1'b0;
      len_q   <= LEN_NONE;
    end else if (process) begin
      if (emit) begin
        phase_q <= PH_FLAGS;
        flags_q <= '0;
        width_q <= '0;
        prec_q  <= '0;
        dot_q   <= 1'b0;
        spn_q   <= 1'b0;
        len_q   <= LEN_NONE;
      end else begin
        phase_q <= phase_d;
        flags_q <= flags_d;
        width_q <= width_d;
        prec_q  <= prec_d;
        dot_q   <= dot_d;
        spn_q   <= spn_d;
        len_q   <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= process && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emit) begin
      out_data_q.valid_res   <= valid_res;
      out_data_q.conv_char   <= ch;
      out_data_q.flag_hash   <= flags_d[FB_HASH];
      out_data_q.flag_minus  <= flags_d[FB_MINUS];
      out_data_q.flag_plus   <= flags_d[FB_PLUS];
      out_data_q.flag_space  <= flags_d[FB_SPACE];
      out_data_q.flag_zero   <= flags_d[FB_ZERO];
      out_data_q.field_width <= width_d;
      out_data_q.has_dot     <= dot_d;
      out_data_q.precision   <= prec_d;
      out_data_q.length_mod  <= len_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[sim/printf_spec_parser_core_tb.sv]
// ----------------------------------------------------------------------------
// printf_spec_parser_core_tb
// Self-checking testbench for the printf conversion spec parser.
// ----------------------------------------------------------------------------
// Streams format characters into the parser and tracks the parse state in a
// behavioral model of its own. Each conversion character queues the record
// the parser must produce. Output records are compared field by field, in
// order, against that queue. Directed specs cover the corner cases. Random
// specs, mostly well-formed with some noise, run under several idle mixes.
// One phase holds the output off for a long stretch to back the parser up.
// ----------------------------------------------------------------------------
`default_nettype none

module printf_spec_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psp_pkg::*;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  psp_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  psp_out_t out_data_o;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  logic        out_hold       = 1'b0;
  int unsigned chars_sent     = 0;
  int unsigned error_count    = 0;

  psp_out_t parsed_specs_q[$];

  // model of the parse state
  psp_phase_e  spec_phase;
  logic [4:0]  spec_flags;
  logic [31:0] spec_width;
  logic [31:0] spec_prec;
  logic        spec_dot;
  logic        spec_star_nz;
  logic [3:0]  spec_len;

  printf_spec_parser_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void clear_spec();
    spec_phase   = PH_FLAGS;
    spec_flags   = '0;
    spec_width   = '0;
    spec_prec    = '0;
    spec_dot     = 1'b0;
    spec_star_nz = 1'b0;
    spec_len     = LEN_NONE;
  endfunction

  function automatic bit is_digit_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [31:0] shift_in_digit(input logic [31:0] acc, input logic [7:0] c);
    logic [63:0] v;
    v = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
    return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
  endfunction

  // Advance the model by one character; returns 1 with the record on a conversion.
  function automatic bit parse_char(input logic [7:0] c, input logic [31:0] a,
                                    output psp_out_t rec);
    logic [32:0] mag;
    bit          ok;
    rec = '0;
    if (spec_phase == PH_FLAGS) begin
      if (c == CH_HASH)  begin spec_flags[FB_HASH]  = 1'b1; return 1'b0; end
      if (c == CH_MINUS) begin spec_flags[FB_MINUS] = 1'b1; return 1'b0; end
      if (c == CH_PLUS)  begin spec_flags[FB_PLUS]  = 1'b1; return 1'b0; end
      if (c == CH_SPACE) begin spec_flags[FB_SPACE] = 1'b1; return 1'b0; end
      if (c == CH_ZERO)  begin spec_flags[FB_ZERO]  = 1'b1; return 1'b0; end
      if (c >= CH_ONE && c <= CH_NINE) begin
        spec_width = 32'(c - CH_ZERO);
        spec_phase = PH_WDIG;
        return 1'b0;
      end
      if (c == CH_STAR) begin
        spec_star_nz = 1'b0;
        spec_phase   = PH_WSTAR;
        return 1'b0;
      end
      spec_phase = PH_DOT;
    end
    if (spec_phase == PH_WDIG) begin
      if (is_digit_char(c)) begin
        spec_width = shift_in_digit(spec_width, c);
        return 1'b0;
      end
      spec_phase = PH_DOT;
    end
    if (spec_phase == PH_WSTAR) begin
      if (is_digit_char(c)) begin
        if (c != CH_ZERO) spec_star_nz = 1'b1;
        return 1'b0;
      end
      // negative star width: left justify, magnitude saturates
      if (a[31]) begin
        mag = 33'h1_0000_0000 - {1'b0, a};
        spec_flags[FB_MINUS] = 1'b1;
        spec_width = (mag > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
        spec_width = a;
      end
      spec_phase = PH_DOT;
      if (spec_star_nz && c == CH_DOLLAR) return 1'b0;
    end
    if (spec_phase == PH_DOT) begin
      if (c == CH_DOT) begin
        spec_dot   = 1'b1;
        spec_phase = PH_PSTART;
        return 1'b0;
      end
      spec_phase = PH_LEN;
    end
    if (spec_phase == PH_PSTART) begin
      if (c == CH_STAR) begin
        spec_star_nz = 1'b0;
        spec_phase   = PH_PSTAR;
        return 1'b0;
      end
      if (is_digit_char(c)) begin
        spec_prec  = 32'(c - CH_ZERO);
        spec_phase = PH_PDIG;
        return 1'b0;
      end
      spec_prec  = '0;
      spec_phase = PH_LEN;
    end
    if (spec_phase == PH_PDIG) begin
      if (is_digit_char(c)) begin
        spec_prec = shift_in_digit(spec_prec, c);
        return 1'b0;
      end
      spec_phase = PH_LEN;
    end
    if (spec_phase == PH_PSTAR) begin
      if (is_digit_char(c)) begin
        if (c != CH_ZERO) spec_star_nz = 1'b1;
        return 1'b0;
      end
      spec_prec  = a;
      spec_phase = PH_LEN;
      if (spec_star_nz && c == CH_DOLLAR) return 1'b0;
    end
    if (spec_phase == PH_LEN) begin
      case (c)
        CH_LOW_H: begin spec_phase = PH_LENH; return 1'b0; end
        CH_LOW_L: begin spec_phase = PH_LENL; return 1'b0; end
        CH_LOW_J: begin spec_len = LEN_J;    spec_phase = PH_CONV; return 1'b0; end
        CH_LOW_Z: begin spec_len = LEN_Z;    spec_phase = PH_CONV; return 1'b0; end
        CH_LOW_T: begin spec_len = LEN_T;    spec_phase = PH_CONV; return 1'b0; end
        CH_UP_L:  begin spec_len = LEN_BIGL; spec_phase = PH_CONV; return 1'b0; end
        default:  spec_phase = PH_CONV;
      endcase
    end else if (spec_phase == PH_LENH) begin
      if (c == CH_LOW_H) begin
        spec_len   = LEN_HH;
        spec_phase = PH_CONV;
        return 1'b0;
      end
      spec_len   = LEN_H;
      spec_phase = PH_CONV;
    end else if (spec_phase == PH_LENL) begin
      if (c == CH_LOW_L) begin
        spec_len   = LEN_LL;
        spec_phase = PH_CONV;
        return 1'b0;
      end
      spec_len   = LEN_L;
      spec_phase = PH_CONV;
    end

    case (c)
      "%", "c", "s", "p", "d", "i", "u", "x", "X", "b",
      "o", "n", "f", "F", "e", "E", "a", "A", "g", "G": ok = 1'b1;
      default: ok = 1'b0;
    endcase
    if ((c == CH_LOW_C || c == CH_LOW_S) && spec_len == LEN_L) ok = 1'b0;
    rec.valid_res   = ok;
    rec.conv_char   = c;
    rec.flag_hash   = spec_flags[FB_HASH];
    rec.flag_minus  = spec_flags[FB_MINUS];
    rec.flag_plus   = spec_flags[FB_PLUS];
    rec.flag_space  = spec_flags[FB_SPACE];
    rec.flag_zero   = spec_flags[FB_ZERO];
    rec.field_width = spec_width[30:0];
    rec.has_dot     = spec_dot;
    rec.precision   = spec_prec;
    rec.length_mod  = spec_len;
    clear_spec();
    return 1'b1;
  endfunction

  task automatic check_record(input psp_out_t got);
    psp_out_t want;
    if (parsed_specs_q.size() == 0) begin
      $error("unexpected record, conv_char 0x%02h", got.conv_char);
      error_count++;
      return;
    end
    want = parsed_specs_q.pop_front();
    if (got.valid_res !== want.valid_res) begin
      $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
      error_count++;
    end
    if (got.conv_char !== want.conv_char) begin
      $error("conv_char: expected 0x%02h, got 0x%02h", want.conv_char, got.conv_char);
      error_count++;
    end
    if (got.flag_hash !== want.flag_hash) begin
      $error("flag_hash: expected %0d, got %0d", want.flag_hash, got.flag_hash);
      error_count++;
    end
    if (got.flag_minus !== want.flag_minus) begin
      $error("flag_minus: expected %0d, got %0d", want.flag_minus, got.flag_minus);
      error_count++;
    end
    if (got.flag_plus !== want.flag_plus) begin
      $error("flag_plus: expected %0d, got %0d", want.flag_plus, got.flag_plus);
      error_count++;
    end
    if (got.flag_space !== want.flag_space) begin
      $error("flag_space: expected %0d, got %0d", want.flag_space, got.flag_space);
      error_count++;
    end
    if (got.flag_zero !== want.flag_zero) begin
      $error("flag_zero: expected %0d, got %0d", want.flag_zero, got.flag_zero);
      error_count++;
    end
    if (got.field_width !== want.field_width) begin
      $error("field_width: expected %0d, got %0d", want.field_width, got.field_width);
      error_count++;
    end
    if (got.has_dot !== want.has_dot) begin
      $error("has_dot: expected %0d, got %0d", want.has_dot, got.has_dot);
      error_count++;
    end
    if (got.precision !== want.precision) begin
      $error("precision: expected %0d, got %0d", want.precision, got.precision);
      error_count++;
    end
    if (got.length_mod !== want.length_mod) begin
      $error("length_mod: expected %0d, got %0d", want.length_mod, got.length_mod);
      error_count++;
    end
  endtask

  // output side: check accepted records, then pick next cycle's stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_record(out_data_o);
    out_stall_i <= out_hold || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd0;
      4:       return $urandom_range(99);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(4))
      0:       return CH_HASH;
      1:       return CH_MINUS;
      2:       return CH_PLUS;
      3:       return CH_SPACE;
      default: return CH_ZERO;
    endcase
  endfunction

  function automatic logic [7:0] pick_conv();
    case ($urandom_range(19))
      0:  return "%";  1:  return "c";  2:  return "s";  3:  return "p";
      4:  return "d";  5:  return "i";  6:  return "u";  7:  return "x";
      8:  return "X";  9:  return "b";  10: return "o";  11: return "n";
      12: return "f";  13: return "F";  14: return "e";  15: return "E";
      16: return "a";  17: return "A";  18: return "g";
      default: return "G";
    endcase
  endfunction

  // mostly short runs, now and then long enough to saturate
  function automatic int digit_count();
    return ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(3, 1);
  endfunction

  // One transaction; valid stays up on return so a back-to-back item needs no toggle.
  task automatic send_char(input logic [7:0] c, input logic [31:0] a);
    psp_out_t rec;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {c, a};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
    if (parse_char(c, a, rec)) parsed_specs_q.push_back(rec);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (parsed_specs_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_digits(input int n, input bit lead_nonzero);
    int         k;
    logic [7:0] d;
    for (k = 0; k < n; k++) begin
      if (k == 0 && lead_nonzero) d = CH_ONE + 8'($urandom_range(8));
      else d = CH_ZERO + 8'($urandom_range(9));
      send_char(d, rand_arg());
    end
  endtask

  // '*' with an optional position; the char ending the digits carries the value
  task automatic send_star();
    send_char(CH_STAR, rand_arg());
    send_digits($urandom_range(2), 1'b0);
    if ($urandom_range(1)) send_char(CH_DOLLAR, rand_arg());
  endtask

  task automatic send_length();
    case ($urandom_range(8))
      1: send_char(CH_LOW_H, rand_arg());
      2: begin send_char(CH_LOW_H, rand_arg()); send_char(CH_LOW_H, rand_arg()); end
      3: send_char(CH_LOW_L, rand_arg());
      4: begin send_char(CH_LOW_L, rand_arg()); send_char(CH_LOW_L, rand_arg()); end
      5: send_char(CH_LOW_J, rand_arg());
      6: send_char(CH_LOW_Z, rand_arg());
      7: send_char(CH_LOW_T, rand_arg());
      8: send_char(CH_UP_L, rand_arg());
      default: ;
    endcase
  endtask

  task automatic send_spec();
    int k;
    int n;
    n = $urandom_range(3);
    for (k = 0; k < n; k++) send_char(pick_flag(), rand_arg());
    case ($urandom_range(2))
      1: send_digits(digit_count(), 1'b1);
      2: send_star();
      default: ;
    endcase
    if ($urandom_range(1)) begin
      send_char(CH_DOT, rand_arg());
      case ($urandom_range(2))
        1: send_digits(digit_count(), 1'b0);
        2: send_star();
        default: ;
      endcase
    end
    send_length();
    if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)), rand_arg());
    else send_char(pick_conv(), rand_arg());
  endtask

  task automatic test_directed();
    // all flags, negative star width at the extreme, negative star precision, ll
    send_char(CH_HASH, rand_arg());
    send_char(CH_MINUS, rand_arg());
    send_char(CH_PLUS, rand_arg());
    send_char(CH_SPACE, rand_arg());
    send_char(CH_ZERO, rand_arg());
    send_char(CH_STAR, rand_arg());
    send_char(CH_DOT, 32'h8000_0000);
    send_char(CH_STAR, rand_arg());
    send_char(CH_LOW_L, 32'h8000_0000);
    send_char(CH_LOW_L, rand_arg());
    send_char("X", rand_arg());
    // NUL terminates with an invalid record
    send_char(8'h00, rand_arg());
    // c with l is rejected
    send_char(CH_LOW_L, rand_arg());
    send_char(CH_LOW_C, rand_arg());
    // nonzero star position consumes the '$'
    send_char(CH_STAR, rand_arg());
    send_char(CH_ONE, rand_arg());
    send_char(CH_DOLLAR, 32'd5);
    send_char(CH_LOW_S, rand_arg());
    // zero position: '$' falls through to the conversion
    send_char(CH_STAR, rand_arg());
    send_char(CH_ZERO, rand_arg());
    send_char(CH_DOLLAR, 32'd7);
    // precision digits may lead with zero
    send_char(CH_DOT, rand_arg());
    send_char(CH_ZERO, rand_arg());
    send_char("7", rand_arg());
    send_char(CH_LOW_J, rand_arg());
    send_char("u", rand_arg());
    send_char(8'hFF, rand_arg());
  endtask

  task automatic test_random_parsing(input int unsigned n_chars);
    int unsigned start;
    int          k;
    int          n;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      if ($urandom_range(99) < 85) begin
        send_spec();
      end else begin
        n = $urandom_range(3, 1);
        for (k = 0; k < n; k++) send_char(8'($urandom_range(255)), rand_arg());
      end
    end
  endtask

  // long output hold-off while the sender keeps pushing complete specs
  task automatic test_output_backpressure();
    int k;
    fork
      begin
        out_hold <= 1'b1;
        repeat (200) @(posedge clk_i);
        out_hold <= 1'b0;
      end
      begin
        for (k = 0; k < 40; k++) send_char(pick_conv(), rand_arg());
      end
    join
  endtask

  task automatic test_drained_restart();
    int k;
    for (k = 0; k < 6; k++) send_spec();
    wait_drained();
    for (k = 0; k < 6; k++) send_spec();
  endtask

  initial begin
    clear_spec();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();

    send_gap_pct   = 32;
    recv_stall_pct = 68;
    test_random_parsing(360);

    send_gap_pct   = 68;
    recv_stall_pct = 32;
    test_random_parsing(360);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_parsing(360);

    test_output_backpressure();
    test_drained_restart();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/psp_pkg.sv
rtl/core/printf_spec_parser_core.sv
sim/printf_spec_parser_core_tb.sv
